// ===== rtl/core/rhh_pkg.sv =====
// Shared types and constants for the RGB to HSV/HSL converter.
package rhh_pkg;

   localparam int CH_BITS      = 16;
   localparam int HUE_NUM_BITS = CH_BITS + 3;
   localparam int QUEUE_DEPTH  = 4;
   // accept edge to result edge: front, queue, operand stage, divider, output
   localparam int PIPE_LATENCY = CH_BITS + 4;

   localparam logic [CH_BITS-1:0] CH_MAX = '1;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   typedef struct packed {
      logic [CH_BITS-1:0] red;
      logic [CH_BITS-1:0] green;
      logic [CH_BITS-1:0] blue;
      logic [CH_BITS-1:0] alpha_in;
   } req_type;

   typedef struct packed {
      logic [CH_BITS-1:0] hue;
      logic [CH_BITS-1:0] saturation;
      logic [CH_BITS-1:0] value_or_lightness;
      logic [CH_BITS-1:0] alpha_out;
   } rsp_type;

   // classified pixel held in the queue; diff is a two's complement difference
   typedef struct packed {
      logic               hsl;
      logic               grey;
      sector_type         sector;
      logic [CH_BITS-1:0] mx;
      logic [CH_BITS-1:0] mn;
      logic [CH_BITS-1:0] span;
      logic [CH_BITS:0]   diff;
      logic [CH_BITS-1:0] alpha;
   } entry_type;

   typedef struct packed {
      logic no_room;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic               grey;
      logic [CH_BITS-1:0] third;
      logic [CH_BITS-1:0] alpha;
   } side_type;

endpackage

// ===== rtl/core/rhh_front.sv =====
// Front end: accepts pixels, finds max/min, sector and the sector difference.
module rhh_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      hsl_mode,
   input  rhh_pkg::req_type          req_data,
   input  rhh_pkg::queue_status_type queue_status,
   output logic                      busy,
   output logic                      push,
   output rhh_pkg::entry_type        entry
);
   import rhh_pkg::*;

   logic      front_valid_ff, front_valid_in;
   entry_type entry_ff, entry_in;
   entry_type classified;
   logic      hold;
   logic      accept;

   always_comb begin
      logic [CH_BITS-1:0] r, g, b, mx, mn;
      r  = req_data.red;
      g  = req_data.green;
      b  = req_data.blue;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;

      classified.hsl   = hsl_mode;
      classified.mx    = mx;
      classified.mn    = mn;
      classified.span  = mx - mn;
      classified.grey  = (mx == mn);
      classified.alpha = req_data.alpha_in;
      // tie for max goes to red, then green
      if (r == mx) begin
         classified.sector = SECTOR_RED;
         classified.diff   = {1'b0, g} - {1'b0, b};
      end else if (g == mx) begin
         classified.sector = SECTOR_GREEN;
         classified.diff   = {1'b0, b} - {1'b0, r};
      end else begin
         classified.sector = SECTOR_BLUE;
         classified.diff   = {1'b0, r} - {1'b0, g};
      end
   end

   assign hold   = front_valid_ff && queue_status.no_room;
   assign busy   = hold;
   assign accept = start && !busy;
   assign push   = front_valid_ff && !queue_status.no_room;
   assign entry  = entry_ff;

   always_comb begin
      front_valid_in = hold ? 1'b1 : accept;
      entry_in       = hold ? entry_ff : classified;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/core/rhh_queue.sv =====
// Short FIFO between the front end and the arithmetic back end.
module rhh_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  rhh_pkg::entry_type        push_entry,
   input  logic                      pop,
   output rhh_pkg::entry_type        head,
   output rhh_pkg::queue_status_type queue_status
);
   import rhh_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(QUEUE_DEPTH);

   entry_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign head                 = mem_ff[rd_ptr_ff];
   assign queue_status.empty   = (count_ff == '0);
   assign queue_status.no_room = (count_ff == FULL_CNT) && !pop;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      count_in = count_ff + CNT_BITS'(push) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != FULL_CNT) || pop)
      else $error("queue written while full");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");
`endif

endmodule

// ===== rtl/core/rhh_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module rhh_divider #(
   parameter int DIVISOR_BITS  = 16,
   parameter int QUOTIENT_BITS = 16
) (
   input  logic                                  clock,
   input  logic [DIVISOR_BITS+QUOTIENT_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]               divisor,
   output logic [QUOTIENT_BITS-1:0]              quotient
);
   // caller guarantees dividend < divisor << QUOTIENT_BITS
   localparam int W = DIVISOR_BITS + QUOTIENT_BITS;

   logic [W-1:0]             rem_ff [QUOTIENT_BITS];
   logic [DIVISOR_BITS-1:0]  dvs_ff [QUOTIENT_BITS];
   logic [QUOTIENT_BITS-1:0] quo_ff [QUOTIENT_BITS];

   for (genvar s = 0; s < QUOTIENT_BITS; s++) begin : g_stage
      logic [W-1:0]             rem_cur, trial;
      logic [DIVISOR_BITS-1:0]  dvs_cur;
      logic [QUOTIENT_BITS-1:0] quo_cur;
      logic                     fits;

      if (s == 0) begin : g_first
         assign rem_cur = dividend;
         assign dvs_cur = divisor;
         assign quo_cur = '0;
      end else begin : g_rest
         assign rem_cur = rem_ff[s-1];
         assign dvs_cur = dvs_ff[s-1];
         assign quo_cur = quo_ff[s-1];
      end

      assign trial = W'(dvs_cur) << (QUOTIENT_BITS - 1 - s);
      assign fits  = (rem_cur >= trial);

      always_ff @(posedge clock) begin
         quo_ff[s] <= (quo_cur << 1) | QUOTIENT_BITS'(fits);
      end

      // last stage only needs its quotient bit
      if (s < QUOTIENT_BITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[s] <= fits ? rem_cur - trial : rem_cur;
            dvs_ff[s] <= dvs_cur;
         end
      end else begin : g_tail
         always_ff @(posedge clock) begin
            rem_ff[s] <= '0;
            dvs_ff[s] <= '0;
         end
      end
   end

   assign quotient = quo_ff[QUOTIENT_BITS-1];

endmodule

// ===== rtl/core/rhh_back.sv =====
// Back end: builds hue and saturation operands, divides, formats the result.
module rhh_back (
   input  logic                      clock,
   input  logic                      reset,
   input  rhh_pkg::entry_type        head,
   input  rhh_pkg::queue_status_type queue_status,
   output logic                      pop,
   output logic                      rsp_valid,
   output rhh_pkg::rsp_type          rsp_data
);
   import rhh_pkg::*;

   localparam int HUE_DIVIDEND_BITS = HUE_NUM_BITS + CH_BITS;
   localparam int SAT_DIVIDEND_BITS = 2 * CH_BITS;

   logic                         vld_a_ff, vld_a_in;
   logic [HUE_DIVIDEND_BITS-1:0] hue_dividend_ff, hue_dividend_in;
   logic [HUE_NUM_BITS-1:0]      hue_divisor_ff, hue_divisor_in;
   logic [SAT_DIVIDEND_BITS-1:0] sat_dividend_ff, sat_dividend_in;
   logic [CH_BITS-1:0]           sat_divisor_ff, sat_divisor_in;
   side_type                     side_a_ff, side_a_in;

   logic                         side_vld_ff [CH_BITS];
   side_type                     side_ff     [CH_BITS];

   logic [CH_BITS-1:0]           hue_q, sat_q;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_ff, rsp_in;

   // the back end never stalls: take an entry whenever one waits
   assign pop      = !queue_status.empty;
   assign vld_a_in = pop;

   always_comb begin
      logic [HUE_NUM_BITS-1:0]        span_x, six_span;
      logic signed [HUE_NUM_BITS:0]   span_s, six_s, diff_s, num_s;
      logic [SAT_DIVIDEND_BITS-1:0]   span_w;
      logic [CH_BITS:0]               sum, two_max, folded;

      span_x   = HUE_NUM_BITS'(head.span);
      six_span = (span_x << 2) + (span_x << 1);
      span_s   = $signed({1'b0, span_x});
      six_s    = $signed({1'b0, six_span});
      diff_s   = (HUE_NUM_BITS + 1)'($signed(head.diff));

      // hue numerator in units of span, wrapped into [0, 6*span)
      case (head.sector)
         SECTOR_RED: begin
            num_s = diff_s[HUE_NUM_BITS] ? diff_s + six_s : diff_s;
         end
         SECTOR_GREEN: begin
            num_s = span_s + span_s + diff_s;
         end
         SECTOR_BLUE: begin
            num_s = (span_s <<< 2) + diff_s;
         end
         default: begin
            num_s = '0;
         end
      endcase

      hue_dividend_in = {num_s[HUE_NUM_BITS-1:0], {CH_BITS{1'b0}}};
      hue_divisor_in  = six_span;

      span_w          = SAT_DIVIDEND_BITS'(head.span);
      sat_dividend_in = (span_w << CH_BITS) - span_w;

      sum     = {1'b0, head.mx} + {1'b0, head.mn};
      two_max = {CH_MAX, 1'b0};
      folded  = two_max - sum;
      if (!head.hsl) begin
         sat_divisor_in = head.mx;
      end else if (sum <= {1'b0, CH_MAX}) begin
         sat_divisor_in = sum[CH_BITS-1:0];
      end else begin
         sat_divisor_in = folded[CH_BITS-1:0];
      end

      side_a_in.grey  = head.grey;
      side_a_in.third = head.hsl ? sum[CH_BITS:1] : head.mx;
      side_a_in.alpha = head.alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else begin
         vld_a_ff <= vld_a_in;
      end
   end

   always_ff @(posedge clock) begin
      hue_dividend_ff <= hue_dividend_in;
      hue_divisor_ff  <= hue_divisor_in;
      sat_dividend_ff <= sat_dividend_in;
      sat_divisor_ff  <= sat_divisor_in;
      side_a_ff       <= side_a_in;
   end

   rhh_divider #(
      .DIVISOR_BITS  (HUE_NUM_BITS),
      .QUOTIENT_BITS (CH_BITS)
   ) u_hue_div (
      .clock    (clock),
      .dividend (hue_dividend_ff),
      .divisor  (hue_divisor_ff),
      .quotient (hue_q)
   );

   rhh_divider #(
      .DIVISOR_BITS  (CH_BITS),
      .QUOTIENT_BITS (CH_BITS)
   ) u_sat_div (
      .clock    (clock),
      .dividend (sat_dividend_ff),
      .divisor  (sat_divisor_ff),
      .quotient (sat_q)
   );

   // side data rides alongside the dividers
   for (genvar s = 0; s < CH_BITS; s++) begin : g_side
      if (s == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               side_vld_ff[s] <= 1'b0;
            end else begin
               side_vld_ff[s] <= vld_a_ff;
            end
         end
         always_ff @(posedge clock) begin
            side_ff[s] <= side_a_ff;
         end
      end else begin : g_rest
         always_ff @(posedge clock) begin
            if (reset) begin
               side_vld_ff[s] <= 1'b0;
            end else begin
               side_vld_ff[s] <= side_vld_ff[s-1];
            end
         end
         always_ff @(posedge clock) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   // grey pixel: quotients are meaningless, force zero
   always_comb begin
      rsp_valid_in              = side_vld_ff[CH_BITS-1];
      rsp_in.hue                = side_ff[CH_BITS-1].grey ? '0 : hue_q;
      rsp_in.saturation         = side_ff[CH_BITS-1].grey ? '0 : sat_q;
      rsp_in.value_or_lightness = side_ff[CH_BITS-1].third;
      rsp_in.alpha_out          = side_ff[CH_BITS-1].alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/rgb_to_hsv_hsl.sv =====
// Top level of the RGB to HSV/HSL pixel converter.
//
// Usage
//  - Request: drive req_data (red, green, blue, alpha_in) and raise start. A
//    transaction is taken at a rising edge with start high and busy low.
//  - Result: rsp_data is shown for exactly one cycle with rsp_valid high and
//    is taken at the edge that ends that cycle; the receiver cannot stall.
//  - CSR: csr_write_enable with csr_write_data writes output_mode
//    (0 = HSV, 1 = HSL). Write it only while no transaction is in flight.
//  - Path: a request passes the front register, the queue, the operand
//    stage, one divider stage per quotient bit and the output register.
//  - Throughput: one pixel per clock. Hue and saturation each use a
//    pipelined restoring divider that retires one quotient bit per stage.
//  - busy rises only when the queue has no room; the back end drains the
//    queue every cycle, so in steady use busy stays low.
//  - Reset (synchronous, active high) empties the front register, the
//    queue and the pipeline valid bits and sets output_mode to HSV.
module rgb_to_hsv_hsl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  rhh_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_valid,
   output rhh_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic             csr_write_data
);
   import rhh_pkg::*;

   logic             mode_ff, mode_in;
   logic             push, pop;
   entry_type        push_entry, head;
   queue_status_type queue_status;

   // output_mode register
   assign mode_in = csr_write_enable ? csr_write_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // front: accept and classify (max/min, sector, grey)
   rhh_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .hsl_mode     (mode_ff),
      .req_data     (req_data),
      .queue_status (queue_status),
      .busy         (busy),
      .push         (push),
      .entry        (push_entry)
   );

   // decoupling queue
   rhh_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_entry   (push_entry),
      .pop          (pop),
      .head         (head),
      .queue_status (queue_status)
   );

   // back: operands, dividers, result register
   rhh_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

`ifndef ASSERT_OFF
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LATENCY rsp_valid)
      else $error("accepted transaction produced no result");
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LATENCY))
      else $error("result without a matching transaction");
`endif

endmodule

// ===== dv/rgb_to_hsv_hsl_checker.sv =====
// Checker for the RGB to HSV/HSL converter: predicts each pixel and compares results.
module rgb_to_hsv_hsl_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  rhh_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  rhh_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic             csr_write_data,
   output int               fail_count,
   output int               pending_count,
   output int               checked_count
);
   import rhh_pkg::*;

   rsp_type expected_pixels[$];
   bit      hsl_selected = 1'b0;
   int      mismatches   = 0;
   int      compared     = 0;

   // Fixed-point conversion of one pixel; quotients round down.
   function automatic rsp_type convert_pixel(req_type px, bit hsl);
      rsp_type              res;
      longint               r, g, b, mx, mn, span, sum, turn_pos, den;
      sector_type           sector;
      longint               full_scale;
      full_scale = longint'(CH_MAX);
      r = longint'(px.red);
      g = longint'(px.green);
      b = longint'(px.blue);
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      span = mx - mn;
      sum  = mx + mn;
      res.alpha_out          = px.alpha_in;
      res.value_or_lightness = hsl ? CH_BITS'(sum >> 1) : CH_BITS'(mx);
      res.hue        = '0;
      res.saturation = '0;
      if (span != 0) begin
         // tie on the maximum goes to red, then green
         if (r == mx)      sector = SECTOR_RED;
         else if (g == mx) sector = SECTOR_GREEN;
         else              sector = SECTOR_BLUE;
         case (sector)
            SECTOR_RED:   turn_pos = g - b;
            SECTOR_GREEN: turn_pos = 2 * span + b - r;
            default:      turn_pos = 4 * span + r - g;
         endcase
         if (turn_pos < 0) turn_pos += 6 * span;
         res.hue = CH_BITS'((turn_pos << CH_BITS) / (6 * span));
         if (!hsl)                  den = mx;
         else if (sum <= full_scale) den = sum;
         else                       den = 2 * full_scale - sum;
         res.saturation = CH_BITS'((span * full_scale) / den);
      end
      return res;
   endfunction

   task automatic compare_field(string name, logic [CH_BITS-1:0] want,
                                logic [CH_BITS-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_edge
      rsp_type want;
      if (reset) begin
         expected_pixels.delete();
         hsl_selected = 1'b0;
      end else begin
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               $error("result with no pending pixel: %h", rsp_data);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               compare_field("hue", want.hue, rsp_data.hue);
               compare_field("saturation", want.saturation, rsp_data.saturation);
               compare_field("value_or_lightness", want.value_or_lightness,
                             rsp_data.value_or_lightness);
               compare_field("alpha_out", want.alpha_out, rsp_data.alpha_out);
               compared++;
            end
         end
         if (start && !busy)
            expected_pixels.push_back(convert_pixel(req_data, hsl_selected));
         if (csr_write_enable)
            hsl_selected = csr_write_data;
      end
      fail_count    <= mismatches;
      pending_count <= expected_pixels.size();
      checked_count <= compared;
   end

endmodule

// ===== dv/rgb_to_hsv_hsl_tb.sv =====
// Testbench top for the RGB to HSV/HSL converter: stimulus, mode writes and verdict.
module rgb_to_hsv_hsl_tb;
   import rhh_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 10;
   localparam int RANDOM_PIXELS = 950;
   localparam int RANDOM_PHASES = 6;      // last phase runs with no sender gaps
   localparam int DRAIN_LIMIT   = 4000;   // cycles allowed to empty the pipe
   localparam int CORNER_COUNT  = 13;

   // output_mode register codes
   localparam logic MODE_HSV = 1'b0;
   localparam logic MODE_HSL = 1'b1;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_data;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_write_enable;
   logic    csr_write_data;

   int      fail_count;
   int      pending_count;
   int      checked_count;

   logic    current_mode;
   bit      all_drained = 1'b1;
   int      hsv_pixels  = 0;
   int      hsl_pixels  = 0;
   int      mode_writes = 0;
   req_type corner_pixels[CORNER_COUNT];

   rgb_to_hsv_hsl u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_data         (req_data),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Watches both channels and the CSR port; owns all prediction and compare.
   rgb_to_hsv_hsl_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count)
   );

   always #HALF_PERIOD clock = ~clock;

   // Hard stop in case a handshake hangs; far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("rgb_to_hsv_hsl_tb: FAIL");
      $finish;
   end

   function automatic req_type make_pixel(logic [CH_BITS-1:0] r, logic [CH_BITS-1:0] g,
                                          logic [CH_BITS-1:0] b, logic [CH_BITS-1:0] a);
      req_type px;
      px.red      = r;
      px.green    = g;
      px.blue     = b;
      px.alpha_in = a;
      return px;
   endfunction

   // Random pixel, biased toward the interesting shapes: greys, ties on the
   // maximum, saturated channels and near-grey pixels with a tiny span.
   function automatic req_type random_pixel();
      logic [CH_BITS-1:0] hi, lo, base;
      req_type            px;
      px.red      = CH_BITS'($urandom_range(0, 65535));
      px.green    = CH_BITS'($urandom_range(0, 65535));
      px.blue     = CH_BITS'($urandom_range(0, 65535));
      px.alpha_in = CH_BITS'($urandom_range(0, 65535));
      hi   = CH_BITS'($urandom_range(0, 65535));
      lo   = CH_BITS'($urandom_range(0, hi));
      base = CH_BITS'($urandom_range(0, 65535 - 8));
      case ($urandom_range(0, 9))
         0: begin
            // grey, including black and white when the draw hits them
            px.green = px.red;
            px.blue  = px.red;
         end
         1: begin
            // two channels share the maximum
            case ($urandom_range(0, 2))
               0:       px = make_pixel(hi, hi, lo, px.alpha_in);
               1:       px = make_pixel(lo, hi, hi, px.alpha_in);
               default: px = make_pixel(hi, lo, hi, px.alpha_in);
            endcase
         end
         2: begin
            // one channel pinned at full scale, one at zero
            case ($urandom_range(0, 2))
               0:       px = make_pixel(CH_MAX, '0, hi, px.alpha_in);
               1:       px = make_pixel(hi, CH_MAX, '0, px.alpha_in);
               default: px = make_pixel('0, hi, CH_MAX, px.alpha_in);
            endcase
         end
         3: begin
            px.red   = base + CH_BITS'($urandom_range(0, 7));
            px.green = base + CH_BITS'($urandom_range(0, 7));
            px.blue  = base + CH_BITS'($urandom_range(0, 7));
         end
         default: ;
      endcase
      return px;
   endfunction

   // One transaction: hold start until the edge with busy low takes it.
   // An optional gap follows; start only drops there, so back-to-back
   // pixels never see start lowered and raised in the same step.
   task automatic send_pixel(input req_type px, input bit may_idle);
      start    <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (busy);
      if (current_mode == MODE_HSL) hsl_pixels++;
      else                          hsv_pixels++;
      if (may_idle && $urandom_range(0, 3) == 0) begin
         start    <= 1'b0;
         req_data <= random_pixel();   // junk on the bus while idle
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // Stop sending and wait for every predicted result to come back.
   // pending_count is registered in the checker, so look at it after the next edge.
   task automatic drain_pipe();
      int waited;
      waited = 0;
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_count != 0) begin
         $error("pipe did not drain: %0d results still missing", pending_count);
         all_drained = 1'b0;
      end
   endtask

   // Mode changes only with nothing in flight. Every pixel yields a result,
   // so an empty prediction queue means the block is idle.
   task automatic set_mode(input logic mode);
      drain_pipe();
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      current_mode = mode;
      mode_writes++;
   endtask

   initial begin
      int per_phase;

      clock            = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = MODE_HSV;
      current_mode     = MODE_HSV;

      // Corner pixels: greys, primaries, ties on the maximum, hue wrap below
      // a full turn, span of one, and both sides of the HSL mx + mn = full
      // scale boundary. Alpha sweeps its extremes along the way.
      corner_pixels[0]  = make_pixel('0, '0, '0, '0);
      corner_pixels[1]  = make_pixel(CH_MAX, CH_MAX, CH_MAX, CH_MAX);
      corner_pixels[2]  = make_pixel(16'h8000, 16'h8000, 16'h8000, 16'h1234);
      corner_pixels[3]  = make_pixel(CH_MAX, '0, '0, CH_MAX);
      corner_pixels[4]  = make_pixel('0, CH_MAX, '0, '0);
      corner_pixels[5]  = make_pixel('0, '0, CH_MAX, 16'hA5A5);
      corner_pixels[6]  = make_pixel(CH_MAX, CH_MAX, '0, 16'h5A5A);
      corner_pixels[7]  = make_pixel('0, CH_MAX, CH_MAX, CH_MAX);
      corner_pixels[8]  = make_pixel(CH_MAX, '0, CH_MAX, '0);
      corner_pixels[9]  = make_pixel(CH_MAX, '0, 16'h0001, 16'h8000);
      corner_pixels[10] = make_pixel(16'h0001, '0, '0, 16'h7FFF);
      corner_pixels[11] = make_pixel(CH_MAX, CH_MAX - 1, CH_MAX - 1, CH_MAX);
      corner_pixels[12] = make_pixel(16'h8001, 16'h7FFF, 16'h7FFF, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: every corner pixel in each mode.
      set_mode(MODE_HSV);
      foreach (corner_pixels[i]) send_pixel(corner_pixels[i], 1'b1);
      set_mode(MODE_HSL);
      foreach (corner_pixels[i]) send_pixel(corner_pixels[i], 1'b1);

      // Random part: phases alternate the mode, each one opened by a full
      // drain before the CSR write. The last phase streams without gaps.
      per_phase = RANDOM_PIXELS / RANDOM_PHASES;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_mode(phase % 2 == 0 ? MODE_HSV : MODE_HSL);
         for (int n = 0; n < per_phase; n++)
            send_pixel(random_pixel(), phase != RANDOM_PHASES - 1);
      end

      drain_pipe();
      repeat (PIPE_LATENCY + 4) @(posedge clock);

      $display("Covered %0d HSV and %0d HSL pixels over %0d mode writes,",
               hsv_pixels, hsl_pixels, mode_writes);
      $display("with %0d results compared against the fixed-point prediction.",
               checked_count);
      if (all_drained && fail_count == 0) begin
         $display("rgb_to_hsv_hsl_tb: PASS");
      end else begin
         $display("rgb_to_hsv_hsl_tb: FAIL");
      end
      $finish;
   end

endmodule
